// File: rtl/grid_raycast_column_top_assert.svh
// Assertion macros shared by the raycaster RTL.
`ifndef GRID_RAYCAST_COLUMN_TOP_ASSERT_SVH
`define GRID_RAYCAST_COLUMN_TOP_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define GRC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define GRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/grc_pkg.sv
// Shared types, codes and the sine table of the column raycaster.
package grc_pkg;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_CAST  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    CFG_PLAYER_X      = 3'd0,
    CFG_PLAYER_Y      = 3'd1,
    CFG_VIEW_DIR      = 3'd2,
    CFG_FIELD_OF_VIEW = 3'd3,
    CFG_SCREEN_WIDTH  = 3'd4,
    CFG_SCREEN_HEIGHT = 3'd5
  } cfg_idx_t;

  // Quarter-wave sine in Q2.14, seventeen points.
  function automatic logic [14:0] sine_tab(input logic [4:0] idx);
    logic [14:0] v;
    case (idx)
      5'd0:  v = 15'd0;
      5'd1:  v = 15'd1606;
      5'd2:  v = 15'd3196;
      5'd3:  v = 15'd4756;
      5'd4:  v = 15'd6270;
      5'd5:  v = 15'd7723;
      5'd6:  v = 15'd9102;
      5'd7:  v = 15'd10394;
      5'd8:  v = 15'd11585;
      5'd9:  v = 15'd12665;
      5'd10: v = 15'd13623;
      5'd11: v = 15'd14449;
      5'd12: v = 15'd15137;
      5'd13: v = 15'd15679;
      5'd14: v = 15'd16069;
      5'd15: v = 15'd16305;
      default: v = 15'd16384;
    endcase
    return v;
  endfunction

  // Interpolated sine of a 16-bit turn angle, signed Q2.14.
  function automatic logic signed [15:0] sine_q14(input logic [15:0] a);
    logic [14:0] r;
    logic [4:0]  idx;
    logic [9:0]  frac;
    logic [14:0] base;
    logic [14:0] upper;
    logic [24:0] prod;
    logic [15:0] s;
    r = {1'b0, a[13:0]};
    if (a[14]) begin
      r = 15'd16384 - r;
    end
    idx  = r[14:10];
    frac = r[9:0];
    base  = sine_tab(idx);
    upper = sine_tab(idx + 5'd1);
    prod  = ({14'd0, 11'(upper - base)} * {15'd0, frac}) + 25'd512;
    if (idx[4]) begin
      s = 16'd16384;
    end else begin
      s = {1'b0, base} + {1'b0, 15'(prod >> 10)};
    end
    return a[15] ? $signed(-s) : $signed(s);
  endfunction

endpackage

// File: rtl/grid_raycast_column_top.sv
// Column raycaster: wall map memory, DDA walker and shared divider.
// A map write item is written in the cycle it is taken. A cast item runs the divider for
// the ray angle and, when it hits a wall, again for the distance and the line height; the
// divider is 29 bits wide at the default map size. A stalled result holds the next item off.
// Each DDA cell takes a step state and a check state, for the map memory's registered read.
// After reset the map is cleared entry by entry with no item taken; config is always taken.
module grid_raycast_column_top #(
  parameter int MAP_SIZE   = 64,
  parameter int MAX_SCREEN = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [9:0]  in_column,
  input  logic [5:0]  in_cell_x,
  input  logic [5:0]  in_cell_y,
  input  logic        in_cell_wall,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [9:0]  out_column,
  output logic [9:0]  out_draw_start,
  output logic [9:0]  out_draw_end,
  output logic        out_hit_side,
  output logic [15:0] out_wall_distance,
  output logic        out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

`include "grid_raycast_column_top_assert.svh"

  localparam int DEPTH = MAP_SIZE * MAP_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int MW    = (($clog2(MAP_SIZE) > 6) ? $clog2(MAP_SIZE) : 6) + 2;
  localparam int NW    = $clog2(1024 * (MAP_SIZE + 2));
  localparam int PW    = NW + 15;
  localparam int DN0   = (NW + 12 > 27) ? NW + 12 : 27;
  localparam int DN    = DN0;
  localparam int DD    = (NW + 4 > 15) ? NW + 4 : 15;
  localparam logic [12:0] MaxScr = 13'(MAX_SCREEN);

  typedef enum logic [9:0] {
    ST_CLR   = 10'b0000000001,
    ST_IDLE  = 10'b0000000010,
    ST_ANG   = 10'b0000000100,
    ST_TRIGX = 10'b0000001000,
    ST_TRIGY = 10'b0000010000,
    ST_STEP  = 10'b0000100000,
    ST_CHECK = 10'b0001000000,
    ST_DIST  = 10'b0010000000,
    ST_LH    = 10'b0100000000,
    ST_FIN   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [15:0] player_x_r, player_y_r, view_dir_r;
  logic [14:0] fov_r;
  logic [10:0] scr_w_r, scr_h_r;
  logic [10:0] w_c, h_c;

  // cast working set
  logic [9:0]           col_r;
  logic                 ang_neg_r;
  logic [15:0]          angle_r;
  logic signed [15:0]   dx_r;
  logic                 dx_neg_r, dy_neg_r;
  logic [14:0]          adx_r, ady_r;
  logic [NW-1:0]        nx_r, ny_r, nhit_r;
  logic [14:0]          dhit_r;
  logic signed [MW-1:0] mx_r, my_r;
  logic                 side_r, stat_r;
  logic [15:0]          dist_r, lh_r;
  logic [AW-1:0]        clr_cnt_r;

  // output register
  logic        out_valid_r;
  logic [9:0]  o_col_r, o_start_r, o_end_r;
  logic        o_side_r, o_stat_r;
  logic [15:0] o_dist_r;

  logic in_acc, out_acc, load_out;

  // memory ports
  logic          ram_we, ram_wdata, ram_rdata;
  logic [AW-1:0] ram_waddr, ram_raddr;

  // divider
  logic          div_start, div_busy, div_done, div_rem_nz;
  logic [DN-1:0] div_dvd, div_quo;
  logic [DD-1:0] div_dvs;

  // combinational helpers
  logic signed [11:0]   cdiff;
  logic [11:0]          cabs;
  logic [26:0]          cmag;
  logic [15:0]          qmag;
  logic [15:0]          trig_arg;
  logic signed [15:0]   trig_val;
  logic [PW-1:0]        prod_x, prod_y;
  logic                 step_x;
  logic signed [MW-1:0] mx_nxt, my_nxt;
  logic                 off_map;
  logic [15:0]          quo_sat;
  logic signed [16:0]   ds, de;
  logic [9:0]           draw_s, draw_e;

  assign w_c = (scr_w_r == 11'd0) ? 11'd1 :
               ({2'b0, scr_w_r} > MaxScr) ? 11'(MAX_SCREEN) : scr_w_r;
  assign h_c = (scr_h_r == 11'd0) ? 11'd1 :
               ({2'b0, scr_h_r} > MaxScr) ? 11'(MAX_SCREEN) : scr_h_r;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid_r && !out_stall;
  assign load_out  = (state_r == ST_FIN) && (!out_valid_r || !out_stall);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      player_x_r <= 16'd1536;
      player_y_r <= 16'd1536;
      view_dir_r <= 16'd0;
      fov_r      <= 15'd10923;
      scr_w_r    <= 11'd320;
      scr_h_r    <= 11'd240;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        grc_pkg::CFG_PLAYER_X:      player_x_r <= cfg_data;
        grc_pkg::CFG_PLAYER_Y:      player_y_r <= cfg_data;
        grc_pkg::CFG_VIEW_DIR:      view_dir_r <= cfg_data;
        grc_pkg::CFG_FIELD_OF_VIEW: fov_r      <= cfg_data[14:0];
        grc_pkg::CFG_SCREEN_WIDTH:  scr_w_r    <= cfg_data[10:0];
        grc_pkg::CFG_SCREEN_HEIGHT: scr_h_r    <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Map memory. Writes happen only in the clearing pass or while idle, so a
  // cast never reads an entry that is being written.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_cnt_r;
    ram_wdata = 1'b0;
    if (state_r == ST_CLR) begin
      ram_we = 1'b1;
    end else if (in_acc && (in_op == grc_pkg::OP_WRITE)) begin
      ram_we    = (int'(in_cell_x) < MAP_SIZE) && (int'(in_cell_y) < MAP_SIZE);
      ram_waddr = AW'(int'(in_cell_y) * MAP_SIZE + int'(in_cell_x));
      ram_wdata = in_cell_wall;
    end
  end

  grc_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Ray offset numerator, split into sign and magnitude for the divider.
  always_comb begin
    cdiff = $signed({1'b0, in_column, 1'b0}) - $signed({1'b0, w_c});
    cabs  = cdiff[11] ? 12'(-cdiff) : 12'(cdiff);
    cmag  = {15'd0, cabs} * {12'd0, fov_r};
  end

  always_comb begin
    div_start = 1'b0;
    div_dvd   = DN'(cmag);
    div_dvs   = DD'({w_c, 1'b0});
    case (state_r)
      ST_IDLE: div_start = in_acc && (in_op == grc_pkg::OP_CAST);
      ST_CHECK: begin
        div_start = ram_rdata;
        div_dvd   = DN'({nhit_r, 12'd0});
        div_dvs   = DD'(dhit_r);
      end
      ST_DIST: begin
        div_start = div_done;
        div_dvd   = DN'({15'd0, h_c} * {11'd0, dhit_r});
        div_dvs   = DD'({nhit_r, 4'd0});
      end
      default: ;
    endcase
  end

  grc_div #(.N(DN), .D(DD)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo),
    .rem_nz   (div_rem_nz)
  );

  // A negative offset rounds towards minus infinity.
  assign qmag    = div_quo[15:0] + {15'd0, ang_neg_r && div_rem_nz};
  assign quo_sat = (|div_quo[DN-1:16]) ? 16'hFFFF : div_quo[15:0];

  assign trig_arg = (state_r == ST_TRIGX) ? angle_r + 16'd16384 : angle_r;
  assign trig_val = grc_pkg::sine_q14(trig_arg);

  // DDA decision: exact cross-multiplied comparison, a tie steps y.
  always_comb begin
    prod_x = PW'(nx_r) * PW'(ady_r);
    prod_y = PW'(ny_r) * PW'(adx_r);
    step_x = prod_x < prod_y;
    mx_nxt = mx_r;
    my_nxt = my_r;
    if (step_x) begin
      mx_nxt = dx_neg_r ? mx_r - MW'(1) : mx_r + MW'(1);
    end else begin
      my_nxt = dy_neg_r ? my_r - MW'(1) : my_r + MW'(1);
    end
    off_map = (mx_nxt < 0) || (int'(mx_nxt) >= MAP_SIZE) ||
              (my_nxt < 0) || (int'(my_nxt) >= MAP_SIZE);
    ram_raddr = AW'(int'(my_nxt) * MAP_SIZE + int'(mx_nxt));
  end

  always_comb begin
    ds = $signed({7'd0, h_c[10:1]}) - $signed({2'd0, lh_r[15:1]});
    de = $signed({7'd0, h_c[10:1]}) + $signed({2'd0, lh_r[15:1]});
    draw_s = ds[16] ? 10'd0 : ds[9:0];
    draw_e = (de >= $signed({6'd0, h_c})) ? 10'(h_c - 11'd1) : de[9:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR:   if (clr_cnt_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_acc && (in_op == grc_pkg::OP_CAST)) state_nxt = ST_ANG;
      ST_ANG:   if (div_done) state_nxt = ST_TRIGX;
      ST_TRIGX: state_nxt = ST_TRIGY;
      ST_TRIGY: begin
        if ((int'(player_x_r[15:10]) >= MAP_SIZE) ||
            (int'(player_y_r[15:10]) >= MAP_SIZE)) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP:  state_nxt = off_map ? ST_FIN : ST_CHECK;
      ST_CHECK: state_nxt = ram_rdata ? ST_DIST : ST_STEP;
      ST_DIST:  if (div_done) state_nxt = ST_LH;
      ST_LH:    if (div_done) state_nxt = ST_FIN;
      ST_FIN:   if (load_out) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        col_r     <= in_column;
        ang_neg_r <= cdiff[11];
        stat_r    <= 1'b0;
        side_r    <= 1'b0;
        dist_r    <= 16'd0;
        lh_r      <= 16'd0;
      end
      ST_ANG: begin
        if (div_done) begin
          angle_r <= ang_neg_r ? view_dir_r - qmag : view_dir_r + qmag;
        end
      end
      ST_TRIGX: begin
        dx_r <= trig_val;
      end
      ST_TRIGY: begin
        dx_neg_r <= dx_r[15];
        dy_neg_r <= trig_val[15];
        adx_r    <= dx_r[15] ? 15'(-dx_r) : 15'(dx_r);
        ady_r    <= trig_val[15] ? 15'(-trig_val) : 15'(trig_val);
        mx_r     <= MW'(player_x_r[15:10]);
        my_r     <= MW'(player_y_r[15:10]);
        nx_r     <= dx_r[15] ? NW'(player_x_r[9:0])
                             : NW'(11'd1024 - {1'b0, player_x_r[9:0]});
        ny_r     <= trig_val[15] ? NW'(player_y_r[9:0])
                                 : NW'(11'd1024 - {1'b0, player_y_r[9:0]});
        if ((int'(player_x_r[15:10]) >= MAP_SIZE) ||
            (int'(player_y_r[15:10]) >= MAP_SIZE)) begin
          stat_r <= 1'b1;
        end
      end
      ST_STEP: begin
        mx_r <= mx_nxt;
        my_r <= my_nxt;
        if (step_x) begin
          nhit_r <= nx_r;
          dhit_r <= adx_r;
          nx_r   <= nx_r + NW'(1024);
          side_r <= 1'b0;
        end else begin
          nhit_r <= ny_r;
          dhit_r <= ady_r;
          ny_r   <= ny_r + NW'(1024);
          side_r <= 1'b1;
        end
        if (off_map) begin
          stat_r <= 1'b1;
        end
      end
      ST_DIST: begin
        if (div_done) begin
          dist_r <= quo_sat;
        end
      end
      ST_LH: begin
        if (div_done) begin
          lh_r <= quo_sat;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_col_r   <= col_r;
      o_stat_r  <= stat_r;
      o_start_r <= stat_r ? 10'd0 : draw_s;
      o_end_r   <= stat_r ? 10'd0 : draw_e;
      o_side_r  <= stat_r ? 1'b0 : side_r;
      o_dist_r  <= stat_r ? 16'd0 : dist_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_column        = o_col_r;
  assign out_draw_start    = o_start_r;
  assign out_draw_end      = o_end_r;
  assign out_hit_side      = o_side_r;
  assign out_wall_distance = o_dist_r;
  assign out_status        = o_stat_r;

  `GRC_ASSERT_IMPL(a_div_start_idle, clk, rst_n, div_start, !div_busy,
                   "divider restarted while busy")
  `GRC_ASSERT_IMPL(a_no_write_in_walk, clk, rst_n,
                   (state_r == ST_STEP) || (state_r == ST_CHECK), !ram_we,
                   "map written during a walk")
  `GRC_ASSERT_NEXT(a_step_to_check, clk, rst_n, state_r == ST_STEP,
                   (state_r == ST_CHECK) || (state_r == ST_FIN),
                   "walk step not followed by check")
  `GRC_ASSERT_IMPL(a_miss_zeroed, clk, rst_n, out_valid && out_status,
                   (out_wall_distance == 16'd0) && !out_hit_side,
                   "miss result carries hit fields")

endmodule

// File: rtl/grc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module grc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/grc_div.sv
// Restoring divider, one quotient bit per cycle.
module grc_div #(
  parameter int N = 32,
  parameter int D = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic         busy,
  output logic         done,
  output logic [N-1:0] quotient,
  output logic         rem_nz
);

  localparam int CW = $clog2(N + 1);

  logic [N-1:0]  quo_r, quo_nxt;
  logic [D-1:0]  rem_r, rem_nxt;
  logic [D-1:0]  dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [D:0]    sh;
  logic          fits;

  // A zero divisor always fits, so the quotient comes out all ones.
  always_comb begin
    sh      = {rem_r, quo_r[N-1]};
    fits    = sh >= {1'b0, dvs_r};
    rem_nxt = fits ? D'(sh - {1'b0, dvs_r}) : sh[D-1:0];
    quo_nxt = {quo_r[N-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(N);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;
  assign rem_nz   = |rem_r;

endmodule
